[rtl/core/kalman_angle_bias_filter_defines.svh]
// assertion macros for the angle and bias filter
`ifndef KALMAN_ANGLE_BIAS_FILTER_DEFINES_SVH
`define KALMAN_ANGLE_BIAS_FILTER_DEFINES_SVH
`ifndef SYNTHESIS
`define KAB_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("kab assertion failed");
`define KAB_ASSERT_NEVER(lbl, clk, rst_n, cond) \
    `KAB_ASSERT(lbl, clk, rst_n, !(cond))
`else
`define KAB_ASSERT(lbl, clk, rst_n, prop)
`define KAB_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

[rtl/core/kab_pkg.sv]
// shared widths, codes and fixed point helpers of the angle and bias filter
`default_nettype none
package kab_pkg;
    localparam int ANGLE_W = 32;
    localparam int IN_W    = 25;
    localparam int DT_W    = 24;
    localparam int NOISE_W = 31;
    localparam int CFG_IDX_W = 2;
    localparam int MUL_A_W = 36;
    localparam int MUL_B_W = 33;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int SUM_W   = 48;

    localparam logic CMD_UPDATE = 1'b0;
    localparam logic CMD_SET    = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_NOISE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BIAS_NOISE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MEAS_NOISE  = 2'd2;

    localparam logic [NOISE_W-1:0] RST_ANGLE_NOISE = 31'd268435;
    localparam logic [NOISE_W-1:0] RST_BIAS_NOISE  = 31'd805306;
    localparam logic [NOISE_W-1:0] RST_MEAS_NOISE  = 31'd8053064;

    localparam logic signed [ANGLE_W-1:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [ANGLE_W-1:0] S32_MIN = 32'sh8000_0000;

    // saturate to signed 32 bits
    function automatic logic signed [ANGLE_W-1:0] f_sat32(input logic signed [SUM_W-1:0] v);
        logic hi_same;
        hi_same = (v[SUM_W-1:ANGLE_W-1] == {(SUM_W-ANGLE_W+1){v[SUM_W-1]}});
        if (hi_same) begin
            return v[ANGLE_W-1:0];
        end
        return v[SUM_W-1] ? S32_MIN : S32_MAX;
    endfunction

    // addend +/- round(prod / 2^s), ties away from zero, then saturate
    function automatic logic signed [ANGLE_W-1:0] f_post(
        input logic signed [PROD_W-1:0] prod,
        input logic                     sh28,
        input logic signed [MUL_B_W-1:0] addend,
        input logic                     sub
    );
        logic              neg;
        logic [PROD_W-1:0] mag;
        logic [PROD_W-1:0] rnd;
        logic signed [SUM_W-1:0] val;
        logic signed [SUM_W-1:0] sum;
        neg = prod[PROD_W-1];
        mag = neg ? (PROD_W'(0) - $unsigned(prod)) : $unsigned(prod);
        if (sh28) begin
            rnd = (mag + (PROD_W'(1) << 27)) >> 28;
        end else begin
            rnd = (mag + (PROD_W'(1) << 23)) >> 24;
        end
        val = $signed(rnd[SUM_W-1:0]);
        if (neg ^ sub) begin
            val = -val;
        end
        sum = SUM_W'(addend) + val;
        return f_sat32(sum);
    endfunction
endpackage
`default_nettype wire

[rtl/core/kab_mul.sv]
// shared signed multiplier with registered product
`default_nettype none
module kab_mul (
    input  wire logic                                i_clk,
    input  wire logic signed [kab_pkg::MUL_A_W-1:0] i_a,
    input  wire logic signed [kab_pkg::MUL_B_W-1:0] i_b,
    output logic signed [kab_pkg::PROD_W-1:0]       o_prod
);
    import kab_pkg::*;

    logic signed [PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(i_a) * PROD_W'(i_b);
    end

    assign o_prod = r_prod;
endmodule
`default_nettype wire

[rtl/core/kab_div.sv]
// gain divider: sat(num * 2^28 / den), truncated, zero for a zero den, one quotient bit per cycle
`default_nettype none
module kab_div (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_start,
    input  wire logic signed [kab_pkg::ANGLE_W-1:0] i_num,
    input  wire logic signed [kab_pkg::MUL_B_W-1:0] i_den,
    output logic                                     o_busy,
    output logic                                     o_done,
    output logic signed [kab_pkg::ANGLE_W-1:0]      o_quot
);
    import kab_pkg::*;

    logic                      r_busy, n_busy;
    logic                      r_done, n_done;
    logic [4:0]                r_cnt, n_cnt;
    logic [MUL_B_W-1:0]        r_rem, n_rem;
    logic [ANGLE_W-1:0]        r_lo, n_lo;
    logic [ANGLE_W-1:0]        r_q, n_q;
    logic [MUL_B_W-1:0]        r_dmag, n_dmag;
    logic                      r_neg, n_neg;
    logic signed [ANGLE_W-1:0] r_quot, n_quot;

    logic [ANGLE_W-1:0] w_nmag;
    logic [MUL_B_W-1:0] w_dmag;
    logic [MUL_B_W:0]   w_trial;
    logic               w_bit;
    logic [ANGLE_W-1:0] w_qmag;
    logic               w_neg;

    function automatic logic signed [ANGLE_W-1:0] f_sat_q(input logic neg,
                                                          input logic [ANGLE_W-1:0] qmag);
        if (neg) begin
            if (qmag > {1'b1, {(ANGLE_W-1){1'b0}}}) begin
                return S32_MIN;
            end
            return $signed(ANGLE_W'(0) - qmag);
        end
        return qmag[ANGLE_W-1] ? S32_MAX : $signed(qmag);
    endfunction

    always_comb begin
        w_nmag  = i_num[ANGLE_W-1] ? (ANGLE_W'(0) - $unsigned(i_num)) : $unsigned(i_num);
        w_dmag  = i_den[MUL_B_W-1] ? (MUL_B_W'(0) - $unsigned(i_den)) : $unsigned(i_den);
        w_neg   = i_num[ANGLE_W-1] ^ i_den[MUL_B_W-1];
        w_trial = {r_rem, r_lo[ANGLE_W-1]};
        w_bit   = (w_trial >= {1'b0, r_dmag});
        w_qmag  = {r_q[ANGLE_W-2:0], w_bit};

        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_lo   = r_lo;
        n_q    = r_q;
        n_dmag = r_dmag;
        n_neg  = r_neg;
        n_quot = r_quot;

        if (r_busy) begin
            n_rem = w_bit ? MUL_B_W'(w_trial - {1'b0, r_dmag}) : w_trial[MUL_B_W-1:0];
            n_lo  = {r_lo[ANGLE_W-2:0], 1'b0};
            n_q   = w_qmag;
            n_cnt = r_cnt + 5'd1;
            if (r_cnt == 5'd31) begin
                n_busy = 1'b0;
                n_done = 1'b1;
                n_quot = f_sat_q(r_neg, w_qmag);
            end
        end else if (i_start) begin
            n_neg  = w_neg;
            n_dmag = w_dmag;
            priority if (w_dmag == '0) begin
                n_quot = '0;
                n_done = 1'b1;
            end else if ({5'd0, w_nmag[ANGLE_W-1:4]} >= w_dmag) begin
                // quotient at least 2^32
                n_quot = w_neg ? S32_MIN : S32_MAX;
                n_done = 1'b1;
            end else begin
                n_rem  = {5'd0, w_nmag[ANGLE_W-1:4]};
                n_lo   = {w_nmag[3:0], 28'd0};
                n_q    = '0;
                n_cnt  = '0;
                n_busy = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem  <= n_rem;
        r_lo   <= n_lo;
        r_q    <= n_q;
        r_dmag <= n_dmag;
        r_neg  <= n_neg;
        r_quot <= n_quot;
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quot = r_quot;
endmodule
`default_nettype wire

[rtl/core/kalman_angle_bias_filter.sv]
// an update runs the predict, gain and correct steps before the output register; set-angle goes straight to it
// throughput: one transaction at a time; the two 32-step gain divisions set most of it
// each multiply has an issue step and a write-back step on the single shared 36x33 multiplier
// a zero divisor or an overflowing quotient ends its division early
// reset (synchronous, active low) clears estimates and covariances and loads default noise
`default_nettype none
`include "kalman_angle_bias_filter_defines.svh"
module kalman_angle_bias_filter (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    // configuration writes
    input  wire logic                                  i_cfg_valid,
    output logic                                       o_cfg_ready,
    input  wire logic [kab_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  wire logic [kab_pkg::NOISE_W-1:0]           i_cfg_data,
    // input transactions
    input  wire logic                                  i_in_valid,
    output logic                                       o_in_stall,
    input  wire logic                                  i_cmd,
    input  wire logic signed [kab_pkg::IN_W-1:0]       i_measured_angle,
    input  wire logic signed [kab_pkg::IN_W-1:0]       i_gyro_rate,
    input  wire logic [kab_pkg::DT_W-1:0]              i_time_step,
    // result transactions
    output logic                                       o_out_valid,
    input  wire logic                                  i_out_stall,
    output logic signed [kab_pkg::ANGLE_W-1:0]         o_angle_estimate,
    output logic signed [kab_pkg::ANGLE_W-1:0]         o_unbiased_rate
);
    import kab_pkg::*;

    // sequencer steps
    localparam logic [4:0] ST_IDLE  = 5'd0;
    localparam logic [4:0] ST_RATE  = 5'd1;   // rate = gyro - bias
    localparam logic [4:0] ST_M_ANG = 5'd2;   // angle += dt * rate
    localparam logic [4:0] ST_M_T   = 5'd3;   // t = dt * p11
    localparam logic [4:0] ST_INNER = 5'd4;   // inner term, predicted p01 and p10
    localparam logic [4:0] ST_M_P00 = 5'd5;
    localparam logic [4:0] ST_M_P11 = 5'd6;
    localparam logic [4:0] ST_S     = 5'd7;   // innovation variance and innovation
    localparam logic [4:0] ST_D0    = 5'd8;   // gain k0
    localparam logic [4:0] ST_D1    = 5'd9;   // gain k1
    localparam logic [4:0] ST_M_K0Y = 5'd10;
    localparam logic [4:0] ST_M_K1Y = 5'd11;
    localparam logic [4:0] ST_M_C00 = 5'd12;
    localparam logic [4:0] ST_M_C01 = 5'd13;
    localparam logic [4:0] ST_M_C10 = 5'd14;
    localparam logic [4:0] ST_M_C11 = 5'd15;
    localparam logic [4:0] ST_OUT   = 5'd16;

    // control
    logic [4:0] r_state, n_state;
    logic       r_ph, n_ph;          // multiply phase: 0 issue, 1 write back; division phase: 0 start, 1 wait for done
    logic       r_out_valid, n_out_valid;

    // configuration
    logic [NOISE_W-1:0] r_qa, n_qa;
    logic [NOISE_W-1:0] r_qb, n_qb;
    logic [NOISE_W-1:0] r_rm, n_rm;

    // filter state
    logic signed [ANGLE_W-1:0] r_angle, n_angle;
    logic signed [ANGLE_W-1:0] r_bias, n_bias;
    logic signed [ANGLE_W-1:0] r_rate, n_rate;
    logic signed [ANGLE_W-1:0] r_caa, n_caa;
    logic signed [ANGLE_W-1:0] r_cab, n_cab;
    logic signed [ANGLE_W-1:0] r_cba, n_cba;
    logic signed [ANGLE_W-1:0] r_cbb, n_cbb;

    // per-transaction working values
    logic signed [IN_W-1:0]    r_meas, n_meas;
    logic signed [IN_W-1:0]    r_gyro, n_gyro;
    logic [DT_W-1:0]           r_dt, n_dt;
    logic signed [ANGLE_W-1:0] r_t, n_t;
    logic signed [MUL_A_W-2:0] r_inner, n_inner;
    logic signed [ANGLE_W-1:0] r_p00, n_p00;
    logic signed [ANGLE_W-1:0] r_p01, n_p01;
    logic signed [ANGLE_W-1:0] r_p10, n_p10;
    logic signed [ANGLE_W-1:0] r_p11, n_p11;
    logic signed [MUL_B_W-1:0] r_s, n_s;
    logic signed [MUL_B_W-1:0] r_y, n_y;
    logic signed [ANGLE_W-1:0] r_k0, n_k0;
    logic signed [ANGLE_W-1:0] r_k1, n_k1;
    logic signed [ANGLE_W-1:0] r_out_angle, n_out_angle;
    logic signed [ANGLE_W-1:0] r_out_rate, n_out_rate;

    // shared units
    logic signed [MUL_A_W-1:0] w_mul_a;
    logic signed [MUL_B_W-1:0] w_mul_b;
    logic signed [PROD_W-1:0]  w_prod;
    logic signed [MUL_B_W-1:0] w_add;
    logic                      w_sh28;
    logic                      w_sub;
    logic signed [ANGLE_W-1:0] w_post;
    logic                      w_div_start;
    logic signed [ANGLE_W-1:0] w_div_num;
    logic                      w_div_busy;
    logic                      w_div_done;
    logic signed [ANGLE_W-1:0] w_div_quot;
    logic signed [MUL_B_W-1:0] w_dt_b;

    kab_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (w_mul_a),
        .i_b    (w_mul_b),
        .o_prod (w_prod)
    );

    kab_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (r_s),
        .o_busy  (w_div_busy),
        .o_done  (w_div_done),
        .o_quot  (w_div_quot)
    );

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != ST_IDLE);

    assign w_dt_b      = $signed({{(MUL_B_W-DT_W){1'b0}}, r_dt});
    assign w_div_start = ((r_state == ST_D0) || (r_state == ST_D1)) && !r_ph;
    assign w_div_num   = (r_state == ST_D0) ? r_p00 : r_p10;

    // operand selection for the multiplier and the round / add / saturate stage
    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        w_add   = '0;
        w_sh28  = 1'b0;
        w_sub   = 1'b0;
        unique case (r_state)
            ST_M_ANG: begin
                w_mul_a = MUL_A_W'(r_rate);
                w_mul_b = w_dt_b;
                w_add   = MUL_B_W'(r_angle);
            end
            ST_M_T: begin
                w_mul_a = MUL_A_W'(r_cbb);
                w_mul_b = w_dt_b;
            end
            ST_M_P00: begin
                w_mul_a = MUL_A_W'(r_inner);
                w_mul_b = w_dt_b;
                w_add   = MUL_B_W'(r_caa);
            end
            ST_M_P11: begin
                w_mul_a = $signed({{(MUL_A_W-NOISE_W){1'b0}}, r_qb});
                w_mul_b = w_dt_b;
                w_add   = MUL_B_W'(r_cbb);
            end
            ST_M_K0Y: begin
                w_mul_a = MUL_A_W'(r_k0);
                w_mul_b = r_y;
                w_add   = MUL_B_W'(r_angle);
                w_sh28  = 1'b1;
            end
            ST_M_K1Y: begin
                w_mul_a = MUL_A_W'(r_k1);
                w_mul_b = r_y;
                w_add   = MUL_B_W'(r_bias);
                w_sh28  = 1'b1;
            end
            ST_M_C00: begin
                w_mul_a = MUL_A_W'(r_k0);
                w_mul_b = MUL_B_W'(r_p00);
                w_add   = MUL_B_W'(r_p00);
                w_sh28  = 1'b1;
                w_sub   = 1'b1;
            end
            ST_M_C01: begin
                w_mul_a = MUL_A_W'(r_k0);
                w_mul_b = MUL_B_W'(r_p01);
                w_add   = MUL_B_W'(r_p01);
                w_sh28  = 1'b1;
                w_sub   = 1'b1;
            end
            ST_M_C10: begin
                w_mul_a = MUL_A_W'(r_k1);
                w_mul_b = MUL_B_W'(r_p00);
                w_add   = MUL_B_W'(r_p10);
                w_sh28  = 1'b1;
                w_sub   = 1'b1;
            end
            ST_M_C11: begin
                w_mul_a = MUL_A_W'(r_k1);
                w_mul_b = MUL_B_W'(r_p01);
                w_add   = MUL_B_W'(r_p11);
                w_sh28  = 1'b1;
                w_sub   = 1'b1;
            end
            default: begin
                w_mul_a = '0;
            end
        endcase
    end

    // rounding uses the product registered in the previous cycle
    assign w_post = f_post(w_prod, w_sh28, w_add, w_sub);

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_ph        = r_ph;
        n_out_valid = r_out_valid;
        n_qa        = r_qa;
        n_qb        = r_qb;
        n_rm        = r_rm;
        n_angle     = r_angle;
        n_bias      = r_bias;
        n_rate      = r_rate;
        n_caa       = r_caa;
        n_cab       = r_cab;
        n_cba       = r_cba;
        n_cbb       = r_cbb;
        n_meas      = r_meas;
        n_gyro      = r_gyro;
        n_dt        = r_dt;
        n_t         = r_t;
        n_inner     = r_inner;
        n_p00       = r_p00;
        n_p01       = r_p01;
        n_p10       = r_p10;
        n_p11       = r_p11;
        n_s         = r_s;
        n_y         = r_y;
        n_k0        = r_k0;
        n_k1        = r_k1;
        n_out_angle = r_out_angle;
        n_out_rate  = r_out_rate;

        // configuration writes; an unused index is dropped
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_ANGLE_NOISE: n_qa = i_cfg_data;
                CFG_BIAS_NOISE:  n_qb = i_cfg_data;
                CFG_MEAS_NOISE:  n_rm = i_cfg_data;
                default:         n_rm = r_rm;
            endcase
        end

        // result taken downstream
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_meas = i_measured_angle;
                    n_gyro = i_gyro_rate;
                    n_dt   = i_time_step;
                    if (i_cmd == CMD_SET) begin
                        // of the filter state, set-angle touches nothing but the angle
                        n_angle = ANGLE_W'(i_measured_angle);
                        n_state = ST_OUT;
                    end else begin
                        n_state = ST_RATE;
                    end
                end
            end
            ST_RATE: begin
                n_rate  = f_sat32(SUM_W'(r_gyro) - SUM_W'(r_bias));
                n_ph    = 1'b0;
                n_state = ST_M_ANG;
            end
            ST_M_ANG, ST_M_T, ST_M_P00, ST_M_P11,
            ST_M_K0Y, ST_M_K1Y, ST_M_C00, ST_M_C01, ST_M_C10, ST_M_C11: begin
                if (!r_ph) begin
                    n_ph = 1'b1;
                end else begin
                    n_ph = 1'b0;
                    unique case (r_state)
                        ST_M_ANG: begin
                            n_angle = w_post;
                            n_state = ST_M_T;
                        end
                        ST_M_T: begin
                            n_t     = w_post;
                            n_state = ST_INNER;
                        end
                        ST_M_P00: begin
                            n_p00   = w_post;
                            n_state = ST_M_P11;
                        end
                        ST_M_P11: begin
                            n_p11   = w_post;
                            n_state = ST_S;
                        end
                        ST_M_K0Y: begin
                            n_angle = w_post;
                            n_state = ST_M_K1Y;
                        end
                        ST_M_K1Y: begin
                            n_bias  = w_post;
                            n_state = ST_M_C00;
                        end
                        ST_M_C00: begin
                            n_caa   = w_post;
                            n_state = ST_M_C01;
                        end
                        ST_M_C01: begin
                            n_cab   = w_post;
                            n_state = ST_M_C10;
                        end
                        ST_M_C10: begin
                            n_cba   = w_post;
                            n_state = ST_M_C11;
                        end
                        default: begin
                            n_cbb   = w_post;
                            n_state = ST_OUT;
                        end
                    endcase
                end
            end
            ST_INNER: begin
                // t - p01 - p10 + q_angle fits in 35 bits
                n_inner = (MUL_A_W-1)'(r_t) - (MUL_A_W-1)'(r_cab) - (MUL_A_W-1)'(r_cba)
                        + $signed({{(MUL_A_W-1-NOISE_W){1'b0}}, r_qa});
                n_p01   = f_sat32(SUM_W'(r_cab) - SUM_W'(r_t));
                n_p10   = f_sat32(SUM_W'(r_cba) - SUM_W'(r_t));
                n_state = ST_M_P00;
            end
            ST_S: begin
                n_s     = MUL_B_W'(r_p00) + $signed({{(MUL_B_W-NOISE_W){1'b0}}, r_rm});
                n_y     = MUL_B_W'(r_meas) - MUL_B_W'(r_angle);
                n_ph    = 1'b0;
                n_state = ST_D0;
            end
            ST_D0, ST_D1: begin
                if (!r_ph) begin
                    n_ph = 1'b1;
                end else if (w_div_done) begin
                    n_ph = 1'b0;
                    if (r_state == ST_D0) begin
                        n_k0    = w_div_quot;
                        n_state = ST_D1;
                    end else begin
                        n_k1    = w_div_quot;
                        n_state = ST_M_K0Y;
                    end
                end
            end
            ST_OUT: begin
                // wait for the output register to free up
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_out_angle = r_angle;
                    n_out_rate  = r_rate;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_ph        <= 1'b0;
            r_out_valid <= 1'b0;
            r_qa        <= RST_ANGLE_NOISE;
            r_qb        <= RST_BIAS_NOISE;
            r_rm        <= RST_MEAS_NOISE;
            r_angle     <= '0;
            r_bias      <= '0;
            r_rate      <= '0;
            r_caa       <= '0;
            r_cab       <= '0;
            r_cba       <= '0;
            r_cbb       <= '0;
        end else begin
            r_state     <= n_state;
            r_ph        <= n_ph;
            r_out_valid <= n_out_valid;
            r_qa        <= n_qa;
            r_qb        <= n_qb;
            r_rm        <= n_rm;
            r_angle     <= n_angle;
            r_bias      <= n_bias;
            r_rate      <= n_rate;
            r_caa       <= n_caa;
            r_cab       <= n_cab;
            r_cba       <= n_cba;
            r_cbb       <= n_cbb;
        end
    end

    always_ff @(posedge i_clk) begin
        r_meas      <= n_meas;
        r_gyro      <= n_gyro;
        r_dt        <= n_dt;
        r_t         <= n_t;
        r_inner     <= n_inner;
        r_p00       <= n_p00;
        r_p01       <= n_p01;
        r_p10       <= n_p10;
        r_p11       <= n_p11;
        r_s         <= n_s;
        r_y         <= n_y;
        r_k0        <= n_k0;
        r_k1        <= n_k1;
        r_out_angle <= n_out_angle;
        r_out_rate  <= n_out_rate;
    end

    assign o_out_valid      = r_out_valid;
    assign o_angle_estimate = r_out_angle;
    assign o_unbiased_rate  = r_out_rate;

    // an accepted transaction always leaves the idle step
    `KAB_ASSERT(a_busy_after_accept, i_clk, i_rst_n, (i_in_valid && !o_in_stall) |=> o_in_stall)
    // results only come out of the output step
    `KAB_ASSERT(a_out_from_seq, i_clk, i_rst_n, $rose(o_out_valid) |-> $past(r_state == ST_OUT))
    // no division left running once the sequencer is back at idle
    `KAB_ASSERT_NEVER(a_div_idle, i_clk, i_rst_n, (r_state == ST_IDLE) && w_div_busy)
endmodule
`default_nettype wire

[bench/tb_top.sv]
// self-checking bench for the angle and bias filter: directed and random transactions
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
    import kab_pkg::*;

    typedef struct {
        logic                     cmd;
        logic signed [IN_W-1:0]   meas;
        logic signed [IN_W-1:0]   rate;
        logic [DT_W-1:0]          dt;
    } imu_sample_t;

    typedef struct {
        logic signed [ANGLE_W-1:0] angle;
        logic signed [ANGLE_W-1:0] rate;
    } estimate_t;

    localparam int MEAS_MAX = 11796480;
    localparam int RATE_MAX = 16384000;
    localparam int DT_MAX   = 16777215;
    localparam int SETTLE_CYCLES = 200;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [NOISE_W-1:0] i_cfg_data = '0;
    logic i_in_valid = 1'b0;
    logic i_cmd = CMD_UPDATE;
    logic signed [IN_W-1:0] i_measured_angle = '0;
    logic signed [IN_W-1:0] i_gyro_rate = '0;
    logic [DT_W-1:0] i_time_step = '0;
    logic i_out_stall = 1'b0;
    logic o_cfg_ready, o_in_stall, o_out_valid;
    logic signed [ANGLE_W-1:0] o_angle_estimate, o_unbiased_rate;

    kalman_angle_bias_filter u_top (.*);

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // predicted filter state and noise settings
    int unsigned q_angle, q_bias, r_meas;
    int est_angle, est_bias, est_rate;
    int p_aa, p_ab, p_ba, p_bb;

    imu_sample_t pending_samples[$];
    estimate_t   expected_estimates[$];
    int          error_count = 0;
    int          send_gap_max = 11;  // 0 gives back-to-back transactions
    bit          long_hold_toggle = 1'b0;

    function automatic int sat32(longint v);
        if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return int'(v);
    endfunction

    // round to nearest, ties away from zero
    function automatic longint round_shift(longint v, int s);
        longint mag, r;
        mag = (v < 0) ? -v : v;
        r = (mag + (64'sd1 <<< (s - 1))) >>> s;
        return (v < 0) ? -r : r;
    endfunction

    function automatic int kalman_gain(longint num, longint den);
        if (den == 0) return 0;
        return sat32((num * (64'sd1 <<< 28)) / den);
    endfunction

    task automatic filter_predict(input imu_sample_t s, output estimate_t e);
        longint meas, dt, t, inner, p00, p01, p10, p11, den, innov;
        int k0, k1;
        meas = longint'(s.meas);
        if (s.cmd == CMD_SET) begin
            est_angle = int'(meas);
        end else begin
            dt = longint'(s.dt);
            // predict
            est_rate  = sat32(longint'(s.rate) - longint'(est_bias));
            est_angle = sat32(longint'(est_angle) + round_shift(dt * est_rate, 24));
            t     = round_shift(dt * longint'(p_bb), 24);
            inner = t - longint'(p_ab) - longint'(p_ba) + longint'(q_angle);
            p00 = sat32(longint'(p_aa) + round_shift(dt * inner, 24));
            p01 = sat32(longint'(p_ab) - t);
            p10 = sat32(longint'(p_ba) - t);
            p11 = sat32(longint'(p_bb) + round_shift(longint'(q_bias) * dt, 24));
            // gains, zero when the innovation variance is zero
            den = p00 + longint'(r_meas);
            k0 = kalman_gain(p00, den);
            k1 = kalman_gain(p10, den);
            // correct, covariance from the predicted p00 and p01
            innov = meas - longint'(est_angle);
            est_angle = sat32(longint'(est_angle) + round_shift(longint'(k0) * innov, 28));
            est_bias  = sat32(longint'(est_bias) + round_shift(longint'(k1) * innov, 28));
            p_aa = sat32(p00 - round_shift(longint'(k0) * p00, 28));
            p_ab = sat32(p01 - round_shift(longint'(k0) * p01, 28));
            p_ba = sat32(p10 - round_shift(longint'(k1) * p00, 28));
            p_bb = sat32(p11 - round_shift(longint'(k1) * p01, 28));
        end
        e.angle = est_angle;
        e.rate  = est_rate;
    endtask

    // input driver: one sample per transaction, random gap after each
    imu_sample_t drv_sample;
    int drv_gap = 0;
    always @(posedge i_clk) begin
        estimate_t e;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                filter_predict(drv_sample, e);
                expected_estimates.push_back(e);
                drv_gap = $urandom_range(0, send_gap_max);
                if (drv_gap == 0 && pending_samples.size() > 0) begin
                    drv_sample = pending_samples.pop_front();
                    i_cmd <= drv_sample.cmd;
                    i_measured_angle <= drv_sample.meas;
                    i_gyro_rate <= drv_sample.rate;
                    i_time_step <= drv_sample.dt;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end else if (!i_in_valid) begin
                if (drv_gap > 0) begin
                    drv_gap--;
                end else if (pending_samples.size() > 0) begin
                    drv_sample = pending_samples.pop_front();
                    i_cmd <= drv_sample.cmd;
                    i_measured_angle <= drv_sample.meas;
                    i_gyro_rate <= drv_sample.rate;
                    i_time_step <= drv_sample.dt;
                    i_in_valid <= 1'b1;
                end
            end
        end
    end

    // result monitor with random stall and an occasional long hold
    int rx_wait = 0;
    int rx_hold = 0;
    bit rx_toggle_seen = 1'b0;
    always @(posedge i_clk) begin
        estimate_t e;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_estimates.size() == 0) begin
                    $display("%0t: unexpected result angle %0d rate %0d", $time,
                             o_angle_estimate, o_unbiased_rate);
                    error_count++;
                end else begin
                    e = expected_estimates.pop_front();
                    if (o_angle_estimate !== e.angle) begin
                        $display("%0t: angle_estimate expected %0d actual %0d", $time,
                                 e.angle, o_angle_estimate);
                        error_count++;
                    end
                    if (o_unbiased_rate !== e.rate) begin
                        $display("%0t: unbiased_rate expected %0d actual %0d", $time,
                                 e.rate, o_unbiased_rate);
                        error_count++;
                    end
                end
                rx_wait = (send_gap_max == 0) ? 0 : $urandom_range(0, 11);
            end else if (rx_wait > 0) begin
                rx_wait--;
            end
            if (long_hold_toggle != rx_toggle_seen) begin
                rx_toggle_seen = long_hold_toggle;
                rx_hold = 400;
            end else if (rx_hold > 0) begin
                rx_hold--;
            end
            i_out_stall <= (rx_wait > 0) || (rx_hold > 0);
        end
    end

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [NOISE_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_ANGLE_NOISE: q_angle = val;
            CFG_BIAS_NOISE:  q_bias = val;
            CFG_MEAS_NOISE:  r_meas = val;
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic push_sample(input logic c, input int m, input int r, input int d);
        imu_sample_t s;
        s.cmd = c;
        s.meas = IN_W'(m);
        s.rate = IN_W'(r);
        s.dt = DT_W'(d);
        pending_samples.push_back(s);
    endtask

    // mostly updates, some set-angle, occasional extreme fields
    task automatic push_random(input int n);
        int m, r, d;
        repeat (n) begin
            m = $urandom_range(0, 2 * MEAS_MAX) - MEAS_MAX;
            r = $urandom_range(0, 2 * RATE_MAX) - RATE_MAX;
            d = ($urandom_range(0, 3) == 0) ? $urandom_range(0, DT_MAX)
                                            : $urandom_range(0, 65535);
            if ($urandom_range(0, 15) == 0) m = $urandom_range(0, 1) ? MEAS_MAX : -MEAS_MAX;
            if ($urandom_range(0, 15) == 0) r = $urandom_range(0, 1) ? RATE_MAX : -RATE_MAX;
            push_sample($urandom_range(0, 9) == 0 ? CMD_SET : CMD_UPDATE, m, r, d);
        end
    endtask

    task automatic drain();
        while (pending_samples.size() > 0 || i_in_valid || expected_estimates.size() > 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        q_angle = RST_ANGLE_NOISE;
        q_bias  = RST_BIAS_NOISE;
        r_meas  = RST_MEAS_NOISE;
        {est_angle, est_bias, est_rate, p_aa, p_ab, p_ba, p_bb} = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: field extremes under default noise
        push_sample(CMD_SET, MEAS_MAX, 0, 0);
        push_sample(CMD_SET, -MEAS_MAX, RATE_MAX, DT_MAX);
        push_sample(CMD_UPDATE, 0, 0, 0);
        push_sample(CMD_UPDATE, MEAS_MAX, RATE_MAX, DT_MAX);
        push_sample(CMD_UPDATE, -MEAS_MAX, -RATE_MAX, DT_MAX);
        push_sample(CMD_UPDATE, MEAS_MAX, -RATE_MAX, 1);
        push_sample(CMD_UPDATE, -MEAS_MAX, RATE_MAX, 0);
        push_sample(CMD_SET, 0, -RATE_MAX, 1);
        push_sample(CMD_UPDATE, 0, RATE_MAX, DT_MAX);
        drain();

        // noise at its maximum, plus a write to the unused index
        cfg_write(CFG_ANGLE_NOISE, '1);
        cfg_write(CFG_BIAS_NOISE, '1);
        cfg_write(CFG_MEAS_NOISE, '1);
        cfg_write(CFG_UNUSED, 31'h1234567);
        push_sample(CMD_UPDATE, MEAS_MAX, RATE_MAX, DT_MAX);
        push_sample(CMD_UPDATE, -MEAS_MAX, -RATE_MAX, DT_MAX);
        push_random(150);
        drain();

        // all noise zero: innovation variance is then the predicted p00 alone
        cfg_write(CFG_ANGLE_NOISE, '0);
        cfg_write(CFG_BIAS_NOISE, '0);
        cfg_write(CFG_MEAS_NOISE, '0);
        push_sample(CMD_UPDATE, MEAS_MAX, RATE_MAX, DT_MAX);
        push_sample(CMD_UPDATE, -MEAS_MAX, 0, 0);
        push_random(100);
        drain();

        // random noise, back-to-back bursts and a long receiver hold
        cfg_write(CFG_ANGLE_NOISE, NOISE_W'($urandom_range(0, 32'h0FFF_FFFF)));
        cfg_write(CFG_BIAS_NOISE, NOISE_W'($urandom_range(0, 32'h0FFF_FFFF)));
        cfg_write(CFG_MEAS_NOISE, NOISE_W'($urandom_range(1, 32'h0FFF_FFFF)));
        send_gap_max = 0;
        long_hold_toggle = ~long_hold_toggle;
        push_random(100);
        while (pending_samples.size() > 0) @(posedge i_clk);
        send_gap_max = 11;
        push_random(250);
        drain();

        // defaults again, sender pauses until all results are back
        cfg_write(CFG_ANGLE_NOISE, RST_ANGLE_NOISE);
        cfg_write(CFG_BIAS_NOISE, RST_BIAS_NOISE);
        cfg_write(CFG_MEAS_NOISE, RST_MEAS_NOISE);
        push_random(190);
        while (pending_samples.size() > 0 || i_in_valid || expected_estimates.size() > 0)
            @(posedge i_clk);
        push_random(190);
        drain();

        if (error_count == 0) begin
            $display("kalman_angle_bias_filter: match");
        end else begin
            $display("kalman_angle_bias_filter: mismatch");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("kalman_angle_bias_filter: mismatch");
        $finish;
    end
endmodule
`default_nettype wire

[filelist.f]
+incdir+rtl/core
rtl/core/kab_pkg.sv
rtl/core/kab_mul.sv
rtl/core/kab_div.sv
rtl/core/kalman_angle_bias_filter.sv
bench/tb_top.sv
